/* rtl/brfm_pkg.sv */
package brfm_pkg;

    localparam int NUM_WORDS = 23;
    localparam int WORD_AW   = $clog2(NUM_WORDS);

    typedef logic [WORD_AW-1:0] slot_t;

    localparam logic [3:0] CMD_READ_REG    = 4'd0;
    localparam logic [3:0] CMD_WRITE_REG   = 4'd1;
    localparam logic [3:0] CMD_READ_CPSR   = 4'd2;
    localparam logic [3:0] CMD_WRITE_CPSR  = 4'd3;
    localparam logic [3:0] CMD_READ_SPSR   = 4'd4;
    localparam logic [3:0] CMD_WRITE_SPSR  = 4'd5;
    localparam logic [3:0] CMD_READ_FLAG   = 4'd6;
    localparam logic [3:0] CMD_WRITE_FLAG  = 4'd7;
    localparam logic [3:0] CMD_CHANGE_MODE = 4'd8;
    localparam logic [3:0] CMD_EXCEPTION   = 4'd9;
    localparam logic [3:0] CMD_CLEAR       = 4'd10;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam int I_BIT = 7;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_PC = 4'd15;

    localparam slot_t SLOT_SP       = slot_t'(13);
    localparam slot_t SLOT_LR       = slot_t'(14);
    localparam slot_t SLOT_PC       = slot_t'(15);
    localparam slot_t SLOT_CPSR     = slot_t'(16);
    localparam slot_t SLOT_SP_SVC   = slot_t'(17);
    localparam slot_t SLOT_LR_SVC   = slot_t'(18);
    localparam slot_t SLOT_SPSR_SVC = slot_t'(19);
    localparam slot_t SLOT_SP_IRQ   = slot_t'(20);
    localparam slot_t SLOT_LR_IRQ   = slot_t'(21);
    localparam slot_t SLOT_SPSR_IRQ = slot_t'(22);

    localparam logic [31:0] PC_OFFSET   = 32'h0000_0008;
    localparam logic [31:0] IRQ_LR_ADJ  = 32'h0000_0004;
    localparam logic [31:0] VEC_SWI     = 32'h0000_0008;
    localparam logic [31:0] VEC_IRQ     = 32'h0000_0018;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  reg_index;
        logic [31:0] write_value;
        logic [4:0]  flag_index;
        logic        flag_value;
        logic [4:0]  mode_value;
        logic        exception_kind;
    } brfm_cmd_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        flag_bit;
        logic [3:0]  nzcv;
        logic [4:0]  current_mode;
    } brfm_rsp_t;

    function automatic slot_t bank_slot(logic [3:0] r, logic [4:0] mode);
        slot_t s;
        s = slot_t'(r);
        if (r == REG_SP || r == REG_LR) begin
            if (mode == MODE_SVC) begin
                s = (r == REG_SP) ? SLOT_SP_SVC : SLOT_LR_SVC;
            end
            else if (mode == MODE_IRQ) begin
                s = (r == REG_SP) ? SLOT_SP_IRQ : SLOT_LR_IRQ;
            end
        end
        return s;
    endfunction

    function automatic slot_t spsr_slot(logic [4:0] mode);
        slot_t s;
        s = SLOT_CPSR;
        if (mode == MODE_SVC) begin
            s = SLOT_SPSR_SVC;
        end
        else if (mode == MODE_IRQ) begin
            s = SLOT_SPSR_IRQ;
        end
        return s;
    endfunction

endpackage

/* rtl/banked_register_file_with_mode.sv */
// Mode-banked register file: r0-r15, banked SP/LR for SVC and IRQ, CPSR and
// SPSRs, accessed by one command per transfer.
//
// Channels: cmd (cmd_valid/cmd_ready/cmd) carries one command per transfer;
// rsp (rsp_valid/rsp_ready/rsp) returns exactly one result per command, in
// order. A result holds read data, the flag bit, NZCV and the mode after the
// command.
//
// Timing: a command is latched in the input register on its transfer, then
// executed into the result register once that register can advance, which
// raises rsp_valid. Throughput is one command per cycle while results are
// taken, set by the single execute stage between the two registers.
//
// Reset: all register words clear to zero, mode goes to SYS (0x1F), and both
// stages are empty.
//
// Stall: while rsp_ready is low the result holds; one more command can wait
// in the input register, after which cmd_ready drops until the result is
// taken.
module banked_register_file_with_mode
    import brfm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  brfm_cmd_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output brfm_rsp_t rsp
);

    logic      cmd_valid_reg;
    brfm_cmd_t cmd_reg;
    logic      rsp_valid_reg;
    brfm_rsp_t rsp_reg;
    brfm_rsp_t result;
    logic      advance;
    logic      exec_en;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign exec_en   = cmd_valid_reg && advance;
    assign cmd_ready = !cmd_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    brfm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .exec_en (exec_en),
        .cmd     (cmd_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_ready)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= cmd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (exec_en)
        begin
            rsp_reg <= result;
        end
    end

    a_exec_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en |=> rsp_valid_reg)
        else $error("executed command produced no result");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && !advance |=> cmd_valid_reg && $stable(cmd_reg))
        else $error("pending command lost during stall");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_ready |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("result changed while stalled");

endmodule

/* rtl/brfm_core.sv */
module brfm_core
    import brfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       exec_en,
    input  brfm_cmd_t  cmd,
    output brfm_rsp_t  result
);

    logic [31:0] words_reg  [NUM_WORDS];
    logic [31:0] words_next [NUM_WORDS];
    logic [4:0]  mode_reg;
    logic [4:0]  mode_next;

    logic [31:0] cpsr;
    logic [31:0] pc;
    logic [31:0] cpsr_mod;
    logic [31:0] rd;
    logic        fb;
    logic [4:0]  exc_mode;
    slot_t       rslot;
    slot_t       sslot;

    assign cpsr     = words_reg[SLOT_CPSR];
    assign pc       = words_reg[SLOT_PC];
    assign rslot    = bank_slot(cmd.reg_index, mode_reg);
    assign sslot    = spsr_slot(mode_reg);
    assign exc_mode = cmd.exception_kind ? MODE_IRQ : MODE_SVC;

    always_comb
    begin
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            words_next[i] = words_reg[i];
        end
        mode_next = mode_reg;
        rd        = '0;
        fb        = 1'b0;
        cpsr_mod  = cpsr;

        unique case (cmd.command)
            CMD_READ_REG:
            begin
                rd = words_reg[rslot];
                if (cmd.reg_index == REG_PC)
                begin
                    rd = words_reg[rslot] + PC_OFFSET;
                end
            end
            CMD_WRITE_REG:
            begin
                words_next[rslot] = cmd.write_value;
            end
            CMD_READ_CPSR:
            begin
                rd = cpsr;
            end
            CMD_WRITE_CPSR:
            begin
                words_next[SLOT_CPSR] = cmd.write_value;
                mode_next             = cmd.write_value[4:0];
            end
            CMD_READ_SPSR:
            begin
                rd = words_reg[sslot];
            end
            CMD_WRITE_SPSR:
            begin
                words_next[sslot] = cmd.write_value;
                if (sslot == SLOT_CPSR)
                begin
                    mode_next = cmd.write_value[4:0];
                end
            end
            CMD_READ_FLAG:
            begin
                fb = cpsr[cmd.flag_index];
            end
            CMD_WRITE_FLAG:
            begin
                cpsr_mod[cmd.flag_index] = cmd.flag_value;
                words_next[SLOT_CPSR]    = cpsr_mod;
                mode_next                = cpsr_mod[4:0];
            end
            CMD_CHANGE_MODE:
            begin
                words_next[SLOT_CPSR] = {cpsr[31:5], cmd.mode_value};
                mode_next             = cmd.mode_value;
            end
            CMD_EXCEPTION:
            begin
                words_next[spsr_slot(exc_mode)]   = cpsr;
                words_next[bank_slot(REG_LR, exc_mode)] =
                    cmd.exception_kind ? (pc + IRQ_LR_ADJ) : pc;
                words_next[SLOT_CPSR] = {cpsr[31:I_BIT+1], 1'b1, cpsr[I_BIT-1:5], exc_mode};
                words_next[SLOT_PC]   = cmd.exception_kind ? VEC_IRQ : VEC_SWI;
                mode_next             = exc_mode;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < 13; i++)
                begin
                    words_next[i] = '0;
                end
                words_next[SLOT_PC]                     = '0;
                words_next[bank_slot(REG_SP, mode_reg)] = '0;
                words_next[bank_slot(REG_LR, mode_reg)] = '0;
                words_next[SLOT_CPSR] = {4'b0000, cpsr[27:0]};
                mode_next             = cpsr[4:0];
            end
            default:
            begin
            end
        endcase
    end

    assign result.read_data    = rd;
    assign result.flag_bit     = fb;
    assign result.nzcv         = words_next[SLOT_CPSR][31:28];
    assign result.current_mode = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
            mode_reg <= MODE_SYS;
        end
        else if (exec_en)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                words_reg[i] <= words_next[i];
            end
            mode_reg <= mode_next;
        end
    end

    a_exc_mode: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && cmd.command == CMD_EXCEPTION
        |=> (mode_reg == MODE_SVC || mode_reg == MODE_IRQ)
            && words_reg[SLOT_CPSR][I_BIT] && words_reg[SLOT_CPSR][4:0] == mode_reg)
        else $error("exception entry left inconsistent mode");

    a_exc_vector: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && cmd.command == CMD_EXCEPTION
        |=> words_reg[SLOT_PC] == VEC_SWI || words_reg[SLOT_PC] == VEC_IRQ)
        else $error("exception entry vector wrong");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        exec_en && cmd.command == CMD_CLEAR
        |=> words_reg[SLOT_CPSR][31:28] == 4'b0000 && words_reg[SLOT_PC] == '0
            && mode_reg == words_reg[SLOT_CPSR][4:0])
        else $error("clear did not zero flags and pc");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_en |=> $stable(mode_reg) && $stable(words_reg[SLOT_CPSR]))
        else $error("state changed without a command");

endmodule
